FILE: src/slp_pkg.sv
// shared constants, types and register map for the sellmeier index and slope unit
// no dependencies; imported by every module of the block except slp_dly
package slp_pkg;

	// quotient bits resolved by each divider; larger quotients saturate
	localparam int QW = 61;
	localparam int DIV_LAT = QW + 2;
	localparam int SQRT_LAT = 32;

	// saturation value of every quotient, 2^60
	localparam logic [QW-1:0] TERM_CAP = {1'b1, {(QW-1){1'b0}}};

	// 1.52 in q2.30
	localparam logic [31:0] IDX_DEFAULT = 32'd1632087572;

	// 256e6 = 2^14 * 15625 scales um^2 against (1/16 nm)^2
	localparam logic [27:0] C_SCALE = 28'd256000000;
	localparam logic [13:0] X_SCALE = 14'd15625;

	localparam logic [31:0] B_ONE_RST = 32'd339674312;
	localparam logic [31:0] B_TWO_RST = 32'd3870600;
	localparam logic [31:0] B_THREE_RST = 32'd269302577;
	localparam logic [31:0] C_ONE_RST = 32'd136416;
	localparam logic [31:0] C_TWO_RST = 32'd911512;
	localparam logic [31:0] C_THREE_RST = 32'd1725052911;

	localparam logic [31:0] SLOPE_NEG_SAT = 32'h8000_0000;
	localparam logic [31:0] SLOPE_POS_SAT = 32'h7FFF_FFFF;
	localparam logic [31:0] IDX_SAT = 32'hFFFF_FFFF;

	// register map, word index
	typedef enum logic [2:0] {
		REG_B_ONE   = 3'd0,
		REG_B_TWO   = 3'd1,
		REG_B_THREE = 3'd2,
		REG_C_ONE   = 3'd3,
		REG_C_TWO   = 3'd4,
		REG_C_THREE = 3'd5
	} reg_idx_t;

endpackage

FILE: src/slp_dly.sv
// enabled shift line that carries valid bits and side data next to a pipelined unit
// depends on nothing but its parameters
module slp_dly #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [DEPTH];

	// shift on every enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tap_s[i] <= '0;
			end
		end else if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

FILE: src/slp_div.sv
// pipelined restoring divider, one quotient bit per stage, result capped at 2^60
// depends on slp_pkg for the quotient width and cap
module slp_div import slp_pkg::*; #(
	parameter int NW = 101,
	parameter int DW = 60
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int HW = NW - QW;
	localparam int MW = (HW > DW) ? HW : DW;

	logic [HW-1:0] hi;
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] lo_s [QW+1];
	logic          ovf_s [QW+1];

	assign hi = num[NW-1:QW];

	// entry: overflow when the quotient cannot fit below 2^61, or zero divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(hi);
			lo_s[0]  <= num[QW-1:0];
			den_s[0] <= den;
			ovf_s[0] <= (den == '0) || (MW'(hi) >= MW'(den));
		end
	end

	// one quotient bit per stage, quotient shifts in at the bottom of lo
	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0] cand;
		logic [DW:0] diff;
		logic        ge;

		assign cand = {rem_s[i], lo_s[i][QW-1]};
		assign diff = cand - {1'b0, den_s[i]};
		assign ge = cand >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[i+1]  <= {lo_s[i][QW-2:0], ge};
				ovf_s[i+1] <= ovf_s[i];
			end
		end

		if (i < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= ge ? diff[DW-1:0] : cand[DW-1:0];
					den_s[i+1] <= den_s[i];
				end
			end
		end
	end

	// saturate
	always_ff @(posedge clk) begin
		if (en) begin
			quo <= (ovf_s[QW] || (lo_s[QW] > TERM_CAP)) ? TERM_CAP : lo_s[QW];
		end
	end

endmodule

FILE: src/slp_sqrt.sv
// pipelined integer square root of a 64-bit word, one root bit per stage
// depends on slp_pkg for the stage count
module slp_sqrt import slp_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] x,
	output logic [31:0] root
);

	logic [34:0] r_s [SQRT_LAT-1];
	logic [63:0] x_s [SQRT_LAT-1];
	logic [31:0] rt_s [SQRT_LAT];

	for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
		logic [34:0] pr;
		logic [31:0] prt;
		logic [63:0] px;
		logic [34:0] rn;
		logic [34:0] t;
		logic        ge;

		if (i == 0) begin : g_first
			assign pr = '0;
			assign prt = '0;
			assign px = x;
		end else begin : g_next
			assign pr = r_s[i-1];
			assign prt = rt_s[i-1];
			assign px = x_s[i-1];
		end

		// bring down two bits, try root*4+1
		assign rn = {pr[32:0], px[63:62]};
		assign t = {1'b0, prt, 2'b01};
		assign ge = rn >= t;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[i] <= {prt[30:0], ge};
			end
		end

		if (i < SQRT_LAT - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[i] <= ge ? (rn - t) : rn;
					x_s[i] <= {px[61:0], 2'b00};
				end
			end
		end
	end

	assign root = rt_s[SQRT_LAT-1];

endmodule

FILE: src/sellmeier_index_and_slope_unit.sv
// top level of the sellmeier index and slope unit: register file, front end and glue
// depends on slp_pkg, slp_dly, slp_div and slp_sqrt
module sellmeier_index_and_slope_unit import slp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               wavelength_valid,
	output logic               wavelength_stall,
	input  logic signed [16:0] wavelength,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        refractive_index,
	output logic signed [31:0] index_slope,
	output logic               pole_flag
);

	// Fully pipelined: one wavelength word is accepted every cycle unless wavelength_stall
	// is high; each word passes four front-end stages, three 63-stage bit-per-stage dividers
	// in sequence, a 32-stage square root and the output register. The whole pipeline
	// advances as one; it holds only while a result word waits under result_stall, and
	// then wavelength_stall is raised in the same cycle. No clearing pass after reset.
	// The user writes coefficients over the APB port while no word is in flight; not enforced.

	typedef struct packed {
		logic             vld;
		logic             neg;
		logic             zero;
		logic             pole;
		logic [2:0]       dneg;
		logic [2:0][59:0] ad;
	} sa_t;

	typedef struct packed {
		logic        vld;
		logic        neg;
		logic        zero;
		logic        pole;
		logic [63:0] s;
	} sb_t;

	typedef struct packed {
		logic        vld;
		logic        neg;
		logic        zero;
		logic        pole;
		logic        slo;
		logic        shi;
		logic [61:0] g;
	} sc_t;

	typedef struct packed {
		logic        vld;
		logic        neg;
		logic        zero;
		logic        pole;
		logic [31:0] n;
	} sd_t;

	logic [2:0][31:0] b_q;
	logic [2:0][31:0] c_q;
	logic [2:0][59:0] cm_q;
	logic [2:0][63:0] bc_q;
	logic             cfg_wr;
	logic             en;

	logic        vld_s1, neg_s1, zero_s1;
	logic [16:0] aw_s1;
	logic [17:0] wext;
	logic [17:0] wneg;
	logic        vld_s2, neg_s2, zero_s2;
	logic [32:0] aw2_s2;
	logic [30:0] x_s2;
	logic        vld_s3, neg_s3, zero_s3;
	logic [2:0]  dneg_s3, dz_s3;
	logic [2:0][59:0]  ad_s3;
	logic [2:0][64:0]  bp_s3;
	logic [2:0][62:0]  bcl_s3, bch_s3;
	logic        vld_s4, neg_s4, zero_s4, pole_s4;
	logic [2:0]  dneg_s4;
	logic [2:0][59:0]  ad_s4;
	logic [2:0][100:0] numt_s4;
	logic [2:0][108:0] numq_s4;

	logic [2:0][QW-1:0] tq, q1, gq;
	logic [QW-1:0] mag;
	logic [31:0]   root;
	logic [63:0]   s_sum;
	logic [61:0]   g_sum;
	logic [31:0]   n_sel;
	sa_t sa_in, sa_out;
	sb_t sb_in, sb_out;
	sc_t sc_in, sc_out;
	sd_t sd_in, sd_out;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q[0] <= B_ONE_RST;
			b_q[1] <= B_TWO_RST;
			b_q[2] <= B_THREE_RST;
			c_q[0] <= C_ONE_RST;
			c_q[1] <= C_TWO_RST;
			c_q[2] <= C_THREE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_B_ONE:   b_q[0] <= pwdata;
				REG_B_TWO:   b_q[1] <= pwdata;
				REG_B_THREE: b_q[2] <= pwdata;
				REG_C_ONE:   c_q[0] <= pwdata;
				REG_C_TWO:   c_q[1] <= pwdata;
				REG_C_THREE: c_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_B_ONE:   prdata = b_q[0];
			REG_B_TWO:   prdata = b_q[1];
			REG_B_THREE: prdata = b_q[2];
			REG_C_ONE:   prdata = c_q[0];
			REG_C_TWO:   prdata = c_q[1];
			REG_C_THREE: prdata = c_q[2];
			default:     prdata = '0;
		endcase
	end

	// coefficient products, settled long before a word reaches them
	for (genvar k = 0; k < 3; k++) begin : g_coef
		always_ff @(posedge clk) begin
			cm_q[k] <= 60'(c_q[k]) * 60'(C_SCALE);
			bc_q[k] <= 64'(b_q[k]) * 64'(c_q[k]);
		end
	end

	// global advance: everything holds while a result word is stalled
	assign en = !(result_valid && result_stall);
	assign wavelength_stall = !en;

	// stage 1: magnitude and sign of the wavelength
	assign wext = {wavelength[16], wavelength};
	assign wneg = -wext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= wavelength_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aw_s1   <= wavelength[16] ? wneg[16:0] : wavelength[16:0];
			neg_s1  <= wavelength[16];
			zero_s1 <= (wavelength == '0);
		end
	end

	// stage 2: squared wavelength and the odd part of the slope scale
	always_ff @(posedge clk) begin
		if (en) begin
			aw2_s2  <= 33'(aw_s1) * 33'(aw_s1);
			x_s2    <= 31'(aw_s1) * 31'(X_SCALE);
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
		end
	end

	// stage 3: denominators and numerator partial products per term
	for (genvar k = 0; k < 3; k++) begin : g_s3
		logic [61:0] diff;
		logic [61:0] ndiff;

		assign diff = {5'b0, aw2_s2, 24'b0} - {2'b0, cm_q[k]};
		assign ndiff = -diff;

		always_ff @(posedge clk) begin
			if (en) begin
				dneg_s3[k] <= diff[61];
				dz_s3[k]   <= (diff == '0);
				ad_s3[k]   <= diff[61] ? ndiff[59:0] : diff[59:0];
				bp_s3[k]   <= 65'(b_q[k]) * 65'(aw2_s2);
				bcl_s3[k]  <= 63'(bc_q[k][31:0]) * 63'(x_s2);
				bch_s3[k]  <= 63'(bc_q[k][63:32]) * 63'(x_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: full dividends
	for (genvar k = 0; k < 3; k++) begin : g_s4
		logic [94:0] bcx;

		assign bcx = {bch_s3[k], 32'b0} + 95'(bcl_s3[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				numt_s4[k] <= {bp_s3[k], 36'b0};
				numq_s4[k] <= {bcx, 14'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			pole_s4 <= |dz_s3;
			dneg_s4 <= dneg_s3;
			ad_s4   <= ad_s3;
		end
	end

	// index terms and first slope quotients
	for (genvar k = 0; k < 3; k++) begin : g_diva
		slp_div #(.NW(101), .DW(60)) u_tdiv (
			.clk(clk), .en(en), .num(numt_s4[k]), .den(ad_s4[k]), .quo(tq[k])
		);
		slp_div #(.NW(109), .DW(60)) u_qdiv (
			.clk(clk), .en(en), .num(numq_s4[k]), .den(ad_s4[k]), .quo(q1[k])
		);
	end

	assign sa_in = '{vld: vld_s4, neg: neg_s4, zero: zero_s4, pole: pole_s4,
		dneg: dneg_s4, ad: ad_s4};

	slp_dly #(.W($bits(sa_t)), .DEPTH(DIV_LAT)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en), .d(sa_in), .q(sa_out)
	);

	// n squared in q.40, signed
	always_comb begin
		s_sum = 64'h1 << 40;
		for (int k = 0; k < 3; k++) begin
			if (sa_out.dneg[k]) begin
				s_sum = s_sum - 64'(tq[k]);
			end else begin
				s_sum = s_sum + 64'(tq[k]);
			end
		end
	end

	// second slope quotients
	for (genvar k = 0; k < 3; k++) begin : g_divb
		slp_div #(.NW(101), .DW(60)) u_gdiv (
			.clk(clk), .en(en), .num({q1[k], 40'b0}), .den(sa_out.ad[k]), .quo(gq[k])
		);
	end

	assign sb_in = '{vld: sa_out.vld, neg: sa_out.neg, zero: sa_out.zero,
		pole: sa_out.pole, s: s_sum};

	slp_dly #(.W($bits(sb_t)), .DEPTH(DIV_LAT)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(en), .d(sb_in), .q(sb_out)
	);

	// slope sum and square root of n squared
	assign g_sum = 62'(gq[0]) + 62'(gq[1]) + 62'(gq[2]);

	slp_sqrt u_sqrt (
		.clk(clk), .en(en), .x({sb_out.s[43:0], 20'b0}), .root(root)
	);

	assign sc_in = '{vld: sb_out.vld, neg: sb_out.neg, zero: sb_out.zero,
		pole: sb_out.pole,
		slo: sb_out.s[63] || (sb_out.s == '0),
		shi: !sb_out.s[63] && (|sb_out.s[62:44]),
		g: g_sum};

	slp_dly #(.W($bits(sc_t)), .DEPTH(SQRT_LAT)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .en(en), .d(sc_in), .q(sc_out)
	);

	// index selection: default for negative wavelength, clamps out of range
	always_comb begin
		priority if (sc_out.neg) begin
			n_sel = IDX_DEFAULT;
		end else if (sc_out.slo) begin
			n_sel = '0;
		end else if (sc_out.shi) begin
			n_sel = IDX_SAT;
		end else begin
			n_sel = root;
		end
	end

	// slope magnitude divided by the index
	slp_div #(.NW(92), .DW(32)) u_mdiv (
		.clk(clk), .en(en), .num({sc_out.g, 30'b0}), .den(n_sel), .quo(mag)
	);

	assign sd_in = '{vld: sc_out.vld, neg: sc_out.neg, zero: sc_out.zero,
		pole: sc_out.pole, n: n_sel};

	slp_dly #(.W($bits(sd_t)), .DEPTH(DIV_LAT)) u_dly_d (
		.clk(clk), .arst_n(arst_n), .en(en), .d(sd_in), .q(sd_out)
	);

	// output word: pole override, sign and saturation of the slope
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= sd_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pole_flag <= sd_out.pole;
			priority if (sd_out.pole) begin
				refractive_index <= sd_out.neg ? IDX_DEFAULT : IDX_SAT;
				index_slope      <= sd_out.neg ? SLOPE_POS_SAT : SLOPE_NEG_SAT;
			end else if (sd_out.zero) begin
				refractive_index <= sd_out.n;
				index_slope      <= '0;
			end else if (!sd_out.neg) begin
				refractive_index <= sd_out.n;
				index_slope      <= (mag >= QW'(SLOPE_NEG_SAT)) ? SLOPE_NEG_SAT
					: 32'(-mag[31:0]);
			end else begin
				refractive_index <= sd_out.n;
				index_slope      <= (mag > QW'(SLOPE_POS_SAT)) ? SLOPE_POS_SAT : mag[31:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_pole_slope: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pole_flag |->
		(index_slope == SLOPE_NEG_SAT || index_slope == SLOPE_POS_SAT))
		else $error("pole word without saturated slope");

	a_pole_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pole_flag |->
		(refractive_index == IDX_SAT || refractive_index == IDX_DEFAULT))
		else $error("pole word with computed index");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		wavelength_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");
`endif

endmodule

FILE: tb/sellmeier_index_and_slope_unit_tb.sv
// testbench for the sellmeier index and slope unit: directed, random and back-pressure tests
// depends on slp_pkg and the sellmeier_index_and_slope_unit rtl; predicts each result word itself
`timescale 1ns / 1ps

module sellmeier_index_and_slope_unit_tb;
	import slp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 600;
	localparam logic [63:0] QUOT_CAP = 64'h1000_0000_0000_0000;
	localparam logic [31:0] INDEX_152 = 32'd1632087572;

	typedef struct {
		logic [31:0] index;
		logic [31:0] slope;
		logic        pole;
	} optic_word_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               wavelength_valid;
	logic               wavelength_stall;
	logic signed [16:0] wavelength;
	logic               result_valid;
	logic               result_stall;
	logic [31:0]        refractive_index;
	logic signed [31:0] index_slope;
	logic               pole_flag;

	// shadow of the coefficient registers, indexed by register
	logic [31:0] coef_shadow [6];
	optic_word_t expected_optics [$];
	int error_count;
	int words_sent;
	int words_checked;
	int poles_seen;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	sellmeier_index_and_slope_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.wavelength_valid (wavelength_valid),
		.wavelength_stall (wavelength_stall),
		.wavelength       (wavelength),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.refractive_index (refractive_index),
		.index_slope      (index_slope),
		.pole_flag        (pole_flag)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(a*b/d) with saturation, d of zero saturates
	function automatic logic [63:0] capped_quotient(logic [63:0] a, logic [63:0] b,
			logic [63:0] d);
		logic [127:0] prod;
		logic [127:0] quot;
		if (d == 64'd0)
			return QUOT_CAP;
		prod = {64'd0, a} * {64'd0, b};
		if (prod[127:64] >= d)
			return QUOT_CAP;
		quot = prod / {64'd0, d};
		return (quot > {64'd0, QUOT_CAP}) ? QUOT_CAP : quot[63:0];
	endfunction

	// integer square root, bit by bit
	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] bitpos;
		root = 64'd0;
		bitpos = 64'd1 << 62;
		while (bitpos > x)
			bitpos = bitpos >> 2;
		while (bitpos != 64'd0) begin
			if (x >= root + bitpos) begin
				x = x - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	// index and slope for one wavelength under the current coefficients
	function automatic optic_word_t predict_optics(logic signed [16:0] wl);
		optic_word_t res;
		logic [63:0] abs_wl;
		logic [63:0] lam_sq;
		longint denom [3];
		logic [63:0] abs_den;
		logic [63:0] term;
		logic [63:0] q1;
		logic [63:0] slope_sum;
		logic [63:0] idx;
		logic [63:0] mag;
		longint n_sq;
		logic has_pole;
		abs_wl = (wl < 0) ? 64'(-longint'(wl)) : 64'(longint'(wl));
		lam_sq = (abs_wl * abs_wl) << 24;
		has_pole = 1'b0;
		n_sq = longint'(1) << 40;
		slope_sum = 64'd0;
		for (int k = 0; k < 3; k++) begin
			denom[k] = longint'(lam_sq) - longint'(64'(coef_shadow[k + 3]) * 64'd256000000);
			if (denom[k] == 0)
				has_pole = 1'b1;
		end
		res.pole = has_pole;
		if (has_pole) begin
			res.index = (wl < 0) ? INDEX_152 : 32'hFFFF_FFFF;
			res.slope = (wl < 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			return res;
		end
		if (wl < 0) begin
			idx = 64'(INDEX_152);
		end else begin
			for (int k = 0; k < 3; k++) begin
				abs_den = (denom[k] < 0) ? 64'(-denom[k]) : 64'(denom[k]);
				term = capped_quotient(64'(coef_shadow[k]) << 12, lam_sq, abs_den);
				n_sq = (denom[k] < 0) ? n_sq - longint'(term) : n_sq + longint'(term);
			end
			if (n_sq <= 0)
				idx = 64'd0;
			else if (n_sq >= (longint'(1) << 44))
				idx = 64'hFFFF_FFFF;
			else
				idx = int_sqrt(64'(n_sq) << 20);
		end
		for (int k = 0; k < 3; k++) begin
			abs_den = (denom[k] < 0) ? 64'(-denom[k]) : 64'(denom[k]);
			q1 = capped_quotient(64'(coef_shadow[k]) * 64'(coef_shadow[k + 3]),
				abs_wl * 64'd256000000, abs_den);
			slope_sum = slope_sum + capped_quotient(q1, 64'd1 << 40, abs_den);
		end
		res.index = idx[31:0];
		if (wl == 0) begin
			res.slope = 32'd0;
		end else begin
			mag = capped_quotient(slope_sum, 64'd1 << 30, idx);
			if (wl > 0)
				res.slope = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
			else
				res.slope = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return res;
	endfunction

	// register write over the apb port, block must be idle
	task automatic write_coef(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		coef_shadow[idx] = value;
		@(posedge clk);
	endtask

	task automatic write_all_coefs(logic [31:0] b1, logic [31:0] b2, logic [31:0] b3,
			logic [31:0] c1, logic [31:0] c2, logic [31:0] c3);
		write_coef(REG_B_ONE, b1);
		write_coef(REG_B_TWO, b2);
		write_coef(REG_B_THREE, b3);
		write_coef(REG_C_ONE, c1);
		write_coef(REG_C_TWO, c2);
		write_coef(REG_C_THREE, c3);
	endtask

	// offer one wavelength word, return at the edge that takes it
	task automatic send_wavelength(logic signed [16:0] wl);
		if ($urandom_range(99) < send_idle_pct) begin
			wavelength_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		wavelength_valid <= 1'b1;
		wavelength       <= wl;
		do
			@(posedge clk);
		while (wavelength_stall);
		expected_optics.push_back(predict_optics(wl));
		words_sent++;
	endtask

	// drop valid and wait for every expected word
	task automatic drain_results();
		wavelength_valid <= 1'b0;
		while (expected_optics.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// wavelength near one of the poles of the current coefficients
	function automatic logic signed [16:0] near_pole_wavelength();
		logic [63:0] target;
		longint wl;
		target = int_sqrt((64'(coef_shadow[3 + $urandom_range(2)]) * 64'd15625) >> 10);
		wl = longint'(target) + longint'($urandom_range(6)) - 3;
		if (wl > 65535)
			wl = 65535;
		if (wl < 0)
			wl = 0;
		if ($urandom_range(9) == 0)
			wl = -wl;
		return 17'(wl);
	endfunction

	function automatic logic signed [16:0] random_wavelength();
		case ($urandom_range(9))
			0, 1, 2: return 17'($urandom);
			3:       return near_pole_wavelength();
			4:       return -17'($urandom_range(65536));
			default: return 17'($urandom_range(20000, 1));
		endcase
	endfunction

	// extremes of the field, reset coefficients, poles, zero and saturated index
	task automatic test_directed();
		logic signed [16:0] edge_wl [10];
		edge_wl = '{17'sd0, 17'sd1, 17'sd16, 17'sd8000, 17'sd9000, 17'sd65535,
			-17'sd65536, -17'sd1, -17'sd8000, 17'sd30000};
		foreach (edge_wl[i])
			send_wavelength(edge_wl[i]);
		drain_results();
		// c_one of 1024 puts a pole at 125 sixteenths of a nanometre
		write_all_coefs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1024, 32'd0, 32'hFFFF_FFFF);
		send_wavelength(17'sd125);
		send_wavelength(-17'sd125);
		send_wavelength(17'sd124);
		send_wavelength(17'sd126);
		send_wavelength(17'sd0);
		send_wavelength(17'sd65535);
		send_wavelength(-17'sd124);
		drain_results();
		write_all_coefs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_wavelength(17'sd0);
		send_wavelength(17'sd500);
		send_wavelength(-17'sd500);
		drain_results();
	endtask

	// a phase of random words under one coefficient setting
	task automatic test_random_phase(int count, int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int i = 0; i < count; i++)
			send_wavelength(random_wavelength());
		drain_results();
	endtask

	// receiver holds off long enough for the pipeline to fill and stall its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 20;
		hold_left = 500;
		for (int i = 0; i < 300; i++)
			send_wavelength(random_wavelength());
		drain_results();
	endtask

	// sender pauses until all words are back, then resumes
	task automatic test_drain_pause();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		for (int i = 0; i < 20; i++)
			send_wavelength(random_wavelength());
		wavelength_valid <= 1'b0;
		while (expected_optics.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 20; i++)
			send_wavelength(random_wavelength());
		drain_results();
	endtask

	// receiver stall, random or held off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each taken result word with the oldest prediction
	always @(posedge clk) begin
		optic_word_t exp_w;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_optics.size() == 0) begin
				$display("%0t: unexpected result word idx=%h slope=%h pole=%b", $time,
					refractive_index, index_slope, pole_flag);
				error_count++;
			end else begin
				exp_w = expected_optics.pop_front();
				words_checked++;
				if (exp_w.pole)
					poles_seen++;
				if (refractive_index !== exp_w.index) begin
					$display("%0t: refractive_index expected %h actual %h", $time,
						exp_w.index, refractive_index);
					error_count++;
				end
				if (index_slope !== exp_w.slope) begin
					$display("%0t: index_slope expected %h actual %h", $time,
						exp_w.slope, index_slope);
					error_count++;
				end
				if (pole_flag !== exp_w.pole) begin
					$display("%0t: pole_flag expected %b actual %b", $time,
						exp_w.pole, pole_flag);
					error_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		words_sent = 0;
		words_checked = 0;
		poles_seen = 0;
		cycle_count = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		wavelength_valid = 1'b0;
		wavelength = '0;
		result_stall = 1'b0;
		coef_shadow = '{B_ONE_RST, B_TWO_RST, B_THREE_RST, C_ONE_RST, C_TWO_RST, C_THREE_RST};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// reset glass coefficients, sender idles more rarely than receiver
		write_all_coefs(B_ONE_RST, B_TWO_RST, B_THREE_RST, C_ONE_RST, C_TWO_RST,
			C_THREE_RST);
		test_random_phase(400, 15, 49);
		// exact poles reachable at multiples of 125
		write_all_coefs($urandom, $urandom, $urandom, 32'd1024 * $urandom_range(524, 1) ** 2,
			32'd1024 * $urandom_range(524, 1) ** 2, 32'd1024 * $urandom_range(524, 1) ** 2);
		test_random_phase(400, 49, 15);
		write_all_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		test_random_phase(150, 0, 0);
		write_all_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		test_random_phase(150, 0, 0);
		test_backpressure();
		test_drain_pause();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d wavelength words, %0d results checked, %0d at a pole",
			words_sent, words_checked, poles_seen);
		if (error_count == 0 && expected_optics.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d words never returned", error_count,
				expected_optics.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sellmeier_index_and_slope_unit.f
src/slp_pkg.sv
src/slp_dly.sv
src/slp_div.sv
src/slp_sqrt.sv
src/sellmeier_index_and_slope_unit.sv
tb/sellmeier_index_and_slope_unit_tb.sv
